>>> hw/rtl/lzwd_pkg.sv
package lzwd_pkg;

    localparam int WINDOW_DEPTH      = 4096;
    localparam int WIN_AW            = $clog2(WINDOW_DEPTH);
    localparam int PROD_W            = WIN_AW + 1;
    localparam int ITEMS_PER_CONTROL = 16;
    localparam int CTRL_CNT_W        = $clog2(ITEMS_PER_CONTROL + 1);
    localparam int LEN_W             = 4;

    localparam logic [7:0] RAW_FLAG    = 8'h01;
    localparam logic       CFG_XOR_KEY = 1'b0;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CTRL_LO,
        PH_CTRL_HI,
        PH_ITEM,
        PH_COPY2,
        PH_RAW
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COPY_RD,
        ST_COPY_WR
    } t_state;

endpackage

>>> hw/rtl/lz_window_decompressor_core.sv
// Streaming LZ decompressor with a 4096-byte history window. Each input beat carries
// one compressed byte, which is XORed with the key register before decoding. Header,
// control and first copy bytes are taken at one per cycle and give no result; literal
// and raw bytes give one output beat each. The second byte of a valid copy of length L
// starts the copy, during which input stalls: every copied byte needs one read and one
// write of the single history memory, whose read data is registered. A copy with a zero offset
// or an offset beyond the bytes produced so far in the block gives a single error beat.
// A byte is accepted only while no copy is running and the output register is free or draining in that cycle.
// History needs no clearing after reset, since the produced count guards every read.
module lz_window_decompressor_core
    import lzwd_pkg::*;
#(
    parameter int HEADER_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_first,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    output logic        o_out_error,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int HDR_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
    localparam logic [HDR_W-1:0] HDR_LAST = HDR_W'(HEADER_BYTES - 1);
    localparam logic [PROD_W-1:0] PROD_MAX = PROD_W'(WINDOW_DEPTH);
    localparam logic [CTRL_CNT_W-1:0] CTRL_FULL = CTRL_CNT_W'(ITEMS_PER_CONTROL);

    logic [7:0] r_hist [WINDOW_DEPTH];
    logic [7:0] r_rd_data;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [HDR_W-1:0]      r_hdr_cnt, n_hdr_cnt;
    logic                  r_raw, n_raw;
    logic [15:0]           r_cw, n_cw;
    logic [CTRL_CNT_W-1:0] r_cl, n_cl;
    logic [7:0]            r_cfb, n_cfb;
    logic [WIN_AW-1:0]     r_wp, n_wp;
    logic [PROD_W-1:0]     r_produced, n_produced;
    logic [WIN_AW-1:0]     r_copy_off, n_copy_off;
    logic [LEN_W-1:0]      r_copy_left, n_copy_left;
    logic [7:0]            r_xor_key;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic       r_out_error;

    logic                  slot_free;
    logic                  in_accept;
    logic [7:0]            key_byte;
    t_phase                e_phase;
    logic [HDR_W-1:0]      e_hdr_cnt;
    logic                  e_raw;
    logic [15:0]           e_cw;
    logic [CTRL_CNT_W-1:0] e_cl;
    logic [7:0]            e_cfb;
    logic [WIN_AW-1:0]     e_wp;
    logic [PROD_W-1:0]     e_produced;
    logic [CTRL_CNT_W-1:0] cl_dec;
    logic [WIN_AW-1:0]     copy_offset;
    logic                  raw_now;

    logic              mem_we;
    logic [WIN_AW-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [WIN_AW-1:0] mem_raddr;

    logic       out_load;
    logic [7:0] out_byte_d;
    logic       out_last_d;
    logic       out_err_d;

    assign slot_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == ST_IDLE) && slot_free);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign key_byte   = i_in_byte ^ r_xor_key;

    // A first-of-block mark clears the decoder before the byte is decoded.
    always_comb begin
        if (in_accept && i_in_first) begin
            e_phase    = PH_HEADER;
            e_hdr_cnt  = '0;
            e_raw      = 1'b0;
            e_cw       = '0;
            e_cl       = '0;
            e_cfb      = '0;
            e_wp       = '0;
            e_produced = '0;
        end else begin
            e_phase    = r_phase;
            e_hdr_cnt  = r_hdr_cnt;
            e_raw      = r_raw;
            e_cw       = r_cw;
            e_cl       = r_cl;
            e_cfb      = r_cfb;
            e_wp       = r_wp;
            e_produced = r_produced;
        end
    end

    assign cl_dec      = (e_cl != '0) ? e_cl - CTRL_CNT_W'(1) : '0;
    assign copy_offset = {e_cfb[7:4], key_byte};
    assign raw_now     = (e_hdr_cnt == '0) ? (key_byte == RAW_FLAG) : e_raw;

    always_comb begin
        n_state     = r_state;
        n_phase     = e_phase;
        n_hdr_cnt   = e_hdr_cnt;
        n_raw       = e_raw;
        n_cw        = e_cw;
        n_cl        = e_cl;
        n_cfb       = e_cfb;
        n_wp        = e_wp;
        n_produced  = e_produced;
        n_copy_off  = r_copy_off;
        n_copy_left = r_copy_left;
        mem_we      = 1'b0;
        mem_waddr   = r_wp;
        mem_wdata   = key_byte;
        mem_re      = 1'b0;
        mem_raddr   = r_wp - r_copy_off;
        out_load    = 1'b0;
        out_byte_d  = key_byte;
        out_last_d  = 1'b1;
        out_err_d   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    unique case (e_phase)
                        PH_HEADER: begin
                            n_raw = raw_now;
                            if (e_hdr_cnt == HDR_LAST) begin
                                n_hdr_cnt = '0;
                                n_phase   = raw_now ? PH_RAW : PH_CTRL_LO;
                            end else begin
                                n_hdr_cnt = e_hdr_cnt + HDR_W'(1);
                            end
                        end
                        PH_CTRL_LO: begin
                            n_cw    = {8'h00, key_byte};
                            n_phase = PH_CTRL_HI;
                        end
                        PH_CTRL_HI: begin
                            n_cw    = {key_byte, e_cw[7:0]};
                            n_cl    = CTRL_FULL;
                            n_phase = PH_ITEM;
                        end
                        PH_ITEM: begin
                            if (e_cw[0]) begin
                                n_cfb   = key_byte;
                                n_phase = PH_COPY2;
                            end else begin
                                mem_we     = 1'b1;
                                mem_waddr  = e_wp;
                                out_load   = 1'b1;
                                n_wp       = e_wp + WIN_AW'(1);
                                n_produced = (e_produced == PROD_MAX) ? e_produced
                                           : e_produced + PROD_W'(1);
                                n_cw       = e_cw >> 1;
                                n_cl       = cl_dec;
                                n_phase    = (cl_dec == '0) ? PH_CTRL_LO : PH_ITEM;
                            end
                        end
                        PH_COPY2: begin
                            if (copy_offset == '0 || {1'b0, copy_offset} > e_produced) begin
                                out_load   = 1'b1;
                                out_byte_d = 8'h00;
                                out_err_d  = 1'b1;
                            end else begin
                                n_copy_off  = copy_offset;
                                n_copy_left = e_cfb[LEN_W-1:0];
                                n_state     = ST_COPY_RD;
                            end
                            n_cw    = e_cw >> 1;
                            n_cl    = cl_dec;
                            n_phase = (cl_dec == '0) ? PH_CTRL_LO : PH_ITEM;
                        end
                        PH_RAW: begin
                            out_load = 1'b1;
                        end
                        default: begin
                            n_phase = PH_HEADER;
                        end
                    endcase
                end
            end
            ST_COPY_RD: begin
                mem_re  = 1'b1;
                n_state = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                if (slot_free) begin
                    mem_we     = 1'b1;
                    mem_waddr  = r_wp;
                    mem_wdata  = r_rd_data;
                    out_load   = 1'b1;
                    out_byte_d = r_rd_data;
                    out_last_d = (r_copy_left == '0);
                    n_wp       = r_wp + WIN_AW'(1);
                    n_produced = (r_produced == PROD_MAX) ? r_produced
                               : r_produced + PROD_W'(1);
                    if (r_copy_left == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_copy_left = r_copy_left - LEN_W'(1);
                        n_state     = ST_COPY_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_hist[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_hist[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_HEADER;
            r_hdr_cnt   <= '0;
            r_raw       <= 1'b0;
            r_cw        <= '0;
            r_cl        <= '0;
            r_cfb       <= '0;
            r_wp        <= '0;
            r_produced  <= '0;
            r_copy_off  <= '0;
            r_copy_left <= '0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_hdr_cnt   <= n_hdr_cnt;
            r_raw       <= n_raw;
            r_cw        <= n_cw;
            r_cl        <= n_cl;
            r_cfb       <= n_cfb;
            r_wp        <= n_wp;
            r_produced  <= n_produced;
            r_copy_off  <= n_copy_off;
            r_copy_left <= n_copy_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_byte  <= out_byte_d;
            r_out_last  <= out_last_d;
            r_out_error <= out_err_d;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;
    assign o_out_error = r_out_error;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xor_key <= '0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == CFG_XOR_KEY)) begin
            r_xor_key <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_XOR_KEY) ? {24'h000000, r_xor_key} : 32'h00000000;

    a_no_accept_in_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_in_stall)
        else $error("input beat taken during a copy");

    a_write_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COPY_WR) |-> ($past(r_state) == ST_COPY_RD ||
                                     $past(r_state) == ST_COPY_WR))
        else $error("copy write without a preceding history read");

    a_copy_in_history: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COPY_RD) |-> (r_copy_off != '0 && {1'b0, r_copy_off} <= r_produced))
        else $error("copy reads history that was not produced");

    a_produced_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_produced <= PROD_MAX)
        else $error("produced count above window depth");

    a_error_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_error) |-> (o_out_last && o_out_byte == 8'h00))
        else $error("error beat with data or without last");

endmodule

>>> tb/sv/tb_top.sv
module tb_top
    import lzwd_pkg::*;
();

    localparam int HEADER_BYTES = 4;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_BEATS = 16;
    localparam int MAX_REPORTS  = 10;
    localparam int MAX_OFFSET   = WINDOW_DEPTH - 1;

    localparam logic [2:0] KEY_ADDR = {CFG_XOR_KEY, 2'b00};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       error;
    } t_out_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_in_byte;
    logic        i_in_first;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_out_byte;
    logic        o_out_last;
    logic        o_out_error;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Decoder shadow state.
    t_phase            dec_phase;
    int                hdr_count;
    logic              raw_mode;
    logic [15:0]       ctrl_word;
    int                ctrl_left;
    logic [7:0]        copy_head;
    logic [7:0]        window_mem [WINDOW_DEPTH];
    logic [WIN_AW-1:0] wr_ptr;
    logic [PROD_W-1:0] produced;
    logic [7:0]        xor_key;
    t_out_beat         expected_beats [$];

    logic       long_copies = 1'b0;
    logic [7:0] copy_tail   = 8'h00;
    int         in_quiet    = 0;
    int         out_quiet   = 0;
    int         in_beats    = 0;
    int         out_beats   = 0;
    int         err_beats   = 0;
    int         blocks      = 0;
    int         key_writes  = 0;
    int         failures    = 0;
    int         idle_cycles = 0;

    lz_window_decompressor_core #(
        .HEADER_BYTES(HEADER_BYTES)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .i_in_first  (i_in_first),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .o_out_error (o_out_error),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit count_failure();
        failures++;
        return failures <= MAX_REPORTS;
    endfunction

    // Mostly random gaps, with occasional runs of back-to-back beats.
    function automatic int draw_gap(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0) begin
            quiet_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic void clear_decoder();
        dec_phase = PH_HEADER;
        hdr_count = 0;
        raw_mode  = 1'b0;
        ctrl_word = '0;
        ctrl_left = 0;
        copy_head = '0;
        wr_ptr    = '0;
        produced  = '0;
    endfunction

    function automatic void emit_beat(input logic [7:0] data, input logic last,
                                      input logic error);
        expected_beats.push_back('{data: data, last: last, error: error});
    endfunction

    function automatic void put_window(input logic [7:0] b);
        window_mem[wr_ptr] = b;
        wr_ptr = wr_ptr + 1'b1;
        if (produced < WINDOW_DEPTH)
            produced = produced + 1'b1;
    endfunction

    function automatic void item_done();
        ctrl_word = ctrl_word >> 1;
        if (ctrl_left > 0)
            ctrl_left--;
        if (ctrl_left == 0)
            dec_phase = PH_CTRL_LO;
        else
            dec_phase = PH_ITEM;
    endfunction

    function automatic void decode_beat(input logic [7:0] coded, input logic first);
        logic [7:0]        b;
        logic [11:0]       offset;
        int                len;
        logic [WIN_AW-1:0] src;
        b = coded ^ xor_key;
        if (first)
            clear_decoder();
        case (dec_phase)
            PH_CTRL_LO: begin
                ctrl_word = {8'h00, b};
                dec_phase = PH_CTRL_HI;
            end
            PH_CTRL_HI: begin
                ctrl_word[15:8] = b;
                ctrl_left = ITEMS_PER_CONTROL;
                dec_phase = PH_ITEM;
            end
            PH_ITEM: begin
                if (ctrl_word[0]) begin
                    copy_head = b;
                    dec_phase = PH_COPY2;
                end else begin
                    put_window(b);
                    emit_beat(b, 1'b1, 1'b0);
                    item_done();
                end
            end
            PH_COPY2: begin
                offset = {copy_head[7:4], b};
                len = copy_head[3:0] + 1;
                if (offset == 0 || offset > produced) begin
                    emit_beat(8'h00, 1'b1, 1'b1);
                end else begin
                    // The source moves along with the write pointer, so short offsets repeat.
                    for (int i = 0; i < len; i++) begin
                        src = wr_ptr - offset;
                        emit_beat(window_mem[src], i == len - 1, 1'b0);
                        put_window(window_mem[src]);
                    end
                end
                item_done();
            end
            PH_RAW: emit_beat(b, 1'b1, 1'b0);
            default: begin
                if (hdr_count == 0)
                    raw_mode = (b == RAW_FLAG);
                hdr_count++;
                if (hdr_count >= HEADER_BYTES) begin
                    hdr_count = 0;
                    if (raw_mode)
                        dec_phase = PH_RAW;
                    else
                        dec_phase = PH_CTRL_LO;
                end
            end
        endcase
    endfunction

    // Returns at the rising edge where the beat was taken.
    task automatic send_beat(input logic [7:0] plain, input logic first);
        int gap;
        @(negedge i_clk);
        gap = draw_gap(in_quiet);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= plain ^ xor_key;
        i_in_first <= first;
        do @(posedge i_clk); while (o_in_stall);
        decode_beat(plain ^ xor_key, first);
        in_beats++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= KEY_ADDR;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        if (wr)
            xor_key = wdata[7:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_key();
        logic [31:0] rdata;
        apb_access(1'b0, 32'h0, rdata);
        if (rdata !== {24'h0, xor_key})
            if (count_failure())
                $display("ERROR: key register read %08h, expected %08h", rdata,
                         {24'h0, xor_key});
    endtask

    task automatic set_key(input logic [7:0] key);
        logic [31:0] rdata;
        apb_access(1'b1, {24'h0, key}, rdata);
        key_writes++;
        check_key();
    endtask

    task automatic start_block(input logic raw);
        logic [7:0] head;
        head = 8'($urandom);
        if (raw)
            head = RAW_FLAG;
        else if (head == RAW_FLAG)
            head = 8'h00;
        send_beat(head, 1'b1);
        repeat (HEADER_BYTES - 1) send_beat(8'($urandom), 1'b0);
        blocks++;
    endtask

    // Sends a byte that fits the current decoder phase; some copies carry a zero or out-of-range offset.
    task automatic send_coded_beat();
        int          max_off;
        int          len;
        logic [11:0] offset;
        case (dec_phase)
            PH_CTRL_LO, PH_CTRL_HI: begin
                // In long-copy mode with an empty history the group opens with a literal so copies have a source.
                if (long_copies)
                    send_beat((dec_phase == PH_CTRL_LO && produced == 0) ? 8'hFE : 8'hFF,
                              1'b0);
                else case ($urandom_range(0, 7))
                    0:       send_beat(8'h00, 1'b0);
                    1:       send_beat(8'hFF, 1'b0);
                    default: send_beat(8'($urandom), 1'b0);
                endcase
            end
            PH_ITEM: begin
                if (ctrl_word[0]) begin
                    max_off = (produced > MAX_OFFSET) ? MAX_OFFSET : int'(produced);
                    if (max_off == 0 || $urandom_range(0, 15) == 0) begin
                        if (max_off < MAX_OFFSET && $urandom_range(0, 1) == 1)
                            offset = 12'($urandom_range(max_off + 1, MAX_OFFSET));
                        else
                            offset = 12'h000;
                    end else if ($urandom_range(0, 7) == 0) begin
                        offset = 12'(max_off);
                    end else if ($urandom_range(0, 1) == 0) begin
                        offset = 12'($urandom_range(1, (max_off < 16) ? max_off : 16));
                    end else begin
                        offset = 12'($urandom_range(1, max_off));
                    end
                    if (long_copies)
                        len = 16;
                    else if ($urandom_range(0, 3) == 0)
                        len = $urandom_range(1, 16);
                    else
                        len = $urandom_range(1, 4);
                    copy_tail = offset[7:0];
                    send_beat({offset[11:8], 4'(len - 1)}, 1'b0);
                end else begin
                    send_beat(8'($urandom), 1'b0);
                end
            end
            PH_COPY2: send_beat(copy_tail, 1'b0);
            default:  send_beat(8'($urandom), 1'b0);
        endcase
    endtask

    task automatic test_register_reset();
        check_key();
    endtask

    task automatic test_directed();
        // No block mark after reset: the first byte still counts as header byte zero.
        // A raw flag later in the header must not select raw mode.
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(RAW_FLAG, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hBC, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        // Zero offset, then an offset past the two bytes produced so far.
        send_beat(8'h00, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hF5, 1'b0);
        send_beat(8'h03, 1'b0);
        // Single byte copy, then a 16-byte copy that overlaps its own output.
        send_beat(8'h00, 1'b0);
        send_beat(8'h01, 1'b0);
        send_beat(8'h0F, 1'b0);
        send_beat(8'h02, 1'b0);
        send_beat(8'hA5, 1'b0);
        // A new block arrives between the two bytes of a copy.
        send_beat(8'h3F, 1'b0);
        send_beat(RAW_FLAG, 1'b1);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(RAW_FLAG, 1'b0);
        blocks += 2;
    endtask

    task automatic test_random_streams(input logic [7:0] key);
        int stop_at;
        int body;
        wait_idle();
        set_key(key);
        stop_at = in_beats + RANDOM_BEATS;
        while (in_beats < stop_at) begin
            start_block($urandom_range(0, 9) == 0);
            body = $urandom_range(4, 60);
            for (int i = 0; i < body; i++) begin
                // Some blocks are cut short by the next header, and a few beats are noise.
                if ($urandom_range(0, 63) == 0)
                    break;
                if ($urandom_range(0, 31) == 0)
                    send_beat(8'($urandom), 1'b0);
                else
                    send_coded_beat();
            end
        end
    endtask

    // Fills the whole history so the produced count saturates and the write pointer wraps.
    task automatic test_window_wrap();
        wait_idle();
        set_key(8'($urandom));
        long_copies = 1'b1;
        start_block(1'b0);
        while (produced < WINDOW_DEPTH) send_coded_beat();
        repeat (16) send_coded_beat();
        long_copies = 1'b0;
    endtask

    initial begin : out_stall_driver
        int wait_cycles;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            wait_cycles = draw_gap(out_quiet);
            if (wait_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_cycles) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin : check_out
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            out_beats++;
            if (o_out_error)
                err_beats++;
            if (expected_beats.size() == 0) begin
                if (count_failure())
                    $display("ERROR: unexpected beat byte %02h last %0b error %0b",
                             o_out_byte, o_out_last, o_out_error);
            end else begin
                want = expected_beats.pop_front();
                if (o_out_byte !== want.data || o_out_last !== want.last ||
                    o_out_error !== want.error)
                    if (count_failure())
                        $display("ERROR: beat %0d expected byte %02h last %0b error %0b, %s",
                                 out_beats, want.data, want.last, want.error,
                                 $sformatf("got byte %02h last %0b error %0b",
                                           o_out_byte, o_out_last, o_out_error));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout after %0d cycles without a beat", idle_cycles);
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_byte  = 8'h00;
        i_in_first = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        xor_key    = 8'h00;
        clear_decoder();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_register_reset();
        test_directed();
        test_random_streams(8'hFF);
        test_random_streams(8'h00);
        test_random_streams(8'($urandom));
        test_window_wrap();
        wait_idle();

        $display("Run covered %0d input beats in %0d blocks over %0d key writes.",
                 in_beats, blocks, key_writes);
        $display("Checked %0d output beats, %0d of them bad-copy beats, with a full window wrap.",
                 out_beats, err_beats);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> lz_window_decompressor_core.f
hw/rtl/lzwd_pkg.sv
hw/rtl/lz_window_decompressor_core.sv
tb/sv/tb_top.sv
